FILE: rtl/utf8d_pkg.sv
// utf8d_pkg: shared types and constants of the utf-8 stream decoder
// holds the result item type and the decode output bundle
// no dependencies
package utf8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned ByteW = 8;

  localparam logic [CpW-1:0] CpQmark = CpW'(63);

  // number of results one byte causes
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ONE  = 2'd1,
    RES_TWO  = 2'd2
  } res_cnt_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           run_last;
    logic           text_done;
  } res_t;

  typedef struct packed {
    res_cnt_t cnt;
    res_t     r0;
    res_t     r1;
  } dec_out_t;

endpackage

FILE: rtl/utf8d_decode.sv
// utf8d_decode: sequence state registers and per-byte decode logic
// produces up to two result items for each accepted byte
// depends on utf8d_pkg
module utf8d_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [utf8d_pkg::ByteW-1:0]  text_byte,
  input  logic                         end_of_text,
  output utf8d_pkg::dec_out_t          dec
);
  import utf8d_pkg::*;

  logic [CpW-1:0] partial_r, partial_nxt;
  logic [1:0]     pending_r, pending_nxt;

  always_comb begin
    logic [CpW-1:0] cp0, cp1;
    logic [1:0]     n;
    logic [CpW-1:0] pp;
    logic [1:0]     pend;
    logic [CpW-1:0] shifted;

    cp0     = '0;
    cp1     = '0;
    n       = 2'd0;
    pp      = partial_r;
    pend    = pending_r;
    shifted = {partial_r[CpW-7:0], text_byte[5:0]};

    if ((pending_r != 2'd0) && (text_byte[7:6] == 2'b10)) begin
      // continuation byte
      pend = pending_r - 2'd1;
      pp   = shifted;
      if (pend == 2'd0) begin
        cp0  = shifted;
        n    = 2'd1;
        pp   = '0;
      end
    end else begin
      // interrupted sequence emits what was gathered
      if (pending_r != 2'd0) begin
        cp0  = partial_r;
        n    = 2'd1;
        pp   = '0;
        pend = 2'd0;
      end
      priority if (text_byte[7] == 1'b0) begin
        if (n == 2'd0) cp0 = CpW'(text_byte);
        else           cp1 = CpW'(text_byte);
        n = n + 2'd1;
      end else if (text_byte[7:5] == 3'b110) begin
        pp   = CpW'(text_byte[4:0]);
        pend = 2'd1;
      end else if (text_byte[7:4] == 4'b1110) begin
        pp   = CpW'(text_byte[3:0]);
        pend = 2'd2;
      end else if (text_byte[7:3] == 5'b11110) begin
        pp   = CpW'(text_byte[2:0]);
        pend = 2'd3;
      end else begin
        if (n == 2'd0) cp0 = CpQmark;
        else           cp1 = CpQmark;
        n = n + 2'd1;
      end
    end

    // end of text flushes an open sequence and clears state
    if (end_of_text) begin
      if (pend != 2'd0) begin
        if (n == 2'd0) cp0 = pp;
        else           cp1 = pp;
        n = n + 2'd1;
      end
      pp   = '0;
      pend = 2'd0;
    end

    partial_nxt = pp;
    pending_nxt = pend;

    dec.r0.code_point = cp0;
    dec.r0.run_last   = (n == 2'd1);
    dec.r0.text_done  = (n == 2'd1) && end_of_text;
    dec.r1.code_point = cp1;
    dec.r1.run_last   = 1'b1;
    dec.r1.text_done  = end_of_text;
    unique case (n)
      2'd0:    dec.cnt = RES_NONE;
      2'd1:    dec.cnt = RES_ONE;
      default: dec.cnt = RES_TWO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pending_r <= 2'd0;
    end else if (take) begin
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

FILE: rtl/utf8d_outq.sv
// utf8d_outq: three-entry result register queue, head always at entry 0
// takes up to two results per cycle, hands out one per transaction
// depends on utf8d_pkg
module utf8d_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utf8d_pkg::dec_out_t  dec,
  input  logic                 pop,
  output utf8d_pkg::res_t      head,
  output logic [1:0]           count
);
  import utf8d_pkg::*;

  localparam int unsigned Depth = 3;

  res_t       q_r   [Depth];
  res_t       q_nxt [Depth];
  logic [1:0] count_r, count_nxt;

  always_comb begin
    logic [1:0] base;
    logic [1:0] added;

    base  = count_r - {1'b0, pop};
    added = 2'd0;
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) q_nxt[i] = q_r[i+1];
      else                        q_nxt[i] = q_r[i];
    end
    if (push) begin
      unique case (dec.cnt)
        RES_NONE: added = 2'd0;
        RES_ONE: begin
          q_nxt[base] = dec.r0;
          added = 2'd1;
        end
        RES_TWO: begin
          q_nxt[base]         = dec.r0;
          q_nxt[base + 2'd1]  = dec.r1;
          added = 2'd2;
        end
        default: added = 2'd0;
      endcase
    end
    count_nxt = base + added;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) q_r[i] <= q_nxt[i];
  end

  assign head  = q_r[0];
  assign count = count_r;

endmodule

FILE: rtl/utf8_stream_decoder_core.sv
// utf8_stream_decoder_core: top level of the streaming utf-8 decoder
// depends on utf8d_pkg, utf8d_decode, utf8d_outq
//
//   channel   direction  signals
//   in_       input      in_valid, in_stall, in_text_byte, in_end_of_text
//   out_      output     out_valid, out_stall, out_code_point, out_run_last, out_text_done
//
// one byte per cycle while in_stall is low; a byte that causes two results holds the input until a result is taken
// the byte is decoded in the accepting cycle and its results land in a 3-entry queue
// in_stall rises while two or more results are queued, so output stalls back up
// synchronous reset clears the sequence state and empties the queue
module utf8_stream_decoder_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [utf8d_pkg::ByteW-1:0]      in_text_byte,
  input  logic                             in_end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [utf8d_pkg::CpW-1:0]        out_code_point,
  output logic                             out_run_last,
  output logic                             out_text_done
);
  import utf8d_pkg::*;

  dec_out_t   dec;
  res_t       head;
  logic [1:0] count;
  logic       take;
  logic       pop;

  assign in_stall  = (count > 2'd1);
  assign take      = in_valid && !in_stall;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;

  utf8d_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .dec         (dec)
  );

  utf8d_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .dec   (dec),
    .pop   (pop),
    .head  (head),
    .count (count)
  );

  assign out_code_point = head.code_point;
  assign out_run_last   = head.run_last;
  assign out_text_done  = head.text_done;

endmodule

FILE: rtl/utf8d_chk.sv
// utf8d_chk: port-level checks for utf8_stream_decoder_core
// attached to the top level by the bind below; depends on utf8d_pkg
module utf8d_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [utf8d_pkg::CpW-1:0]   out_code_point,
  input logic                        out_run_last,
  input logic                        out_text_done
);
  import utf8d_pkg::*;

  // the final result of a string is always the last one of its byte
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_text_done || out_run_last))
    else $error("text_done without run_last");

  // input only backs up when results are waiting
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result queue");

  // an idle decoder comes out of reset able to take a byte
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("not empty after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point)
      && $stable(out_run_last) && $stable(out_text_done))
    else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_core utf8d_chk u_utf8d_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_code_point (out_code_point),
  .out_run_last   (out_run_last),
  .out_text_done  (out_text_done)
);

FILE: tb/utf8_stream_decoder_core_test.sv
// utf8_stream_decoder_core_test: self-checking bench for the streaming utf-8 decoder
// drives bytes through the valid/stall input channel and checks every decoded code point
// depends on utf8d_pkg and utf8_stream_decoder_core
`timescale 1ns / 100ps

module utf8_stream_decoder_core_test;
  import utf8d_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 16;
  localparam int RandomBytes = 1750;

  // lead byte prefixes and the continuation marker
  localparam logic [2:0] LeadTwo   = 3'b110;
  localparam logic [3:0] LeadThree = 4'b1110;
  localparam logic [4:0] LeadFour  = 5'b11110;
  localparam logic [1:0] ContMark  = 2'b10;

  typedef struct packed {
    logic [ByteW-1:0] text;
    logic             eot;
  } text_byte_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_text_byte = '0;
  logic             in_end_of_text = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CpW-1:0]   out_code_point;
  logic             out_run_last;
  logic             out_text_done;

  text_byte_t byte_q[$];
  res_t       decoded_q[$];
  text_byte_t next_byte;

  // decoder state as predicted
  logic [CpW-1:0] seq_point = '0;
  logic [1:0]     seq_left = '0;

  int  err_count = 0;
  int  cyc = 0;
  int  quiet_cycles = 0;
  logic calm;

  utf8_stream_decoder_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last),
    .out_text_done  (out_text_done)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // stretch with no idling on either side
  assign calm = (cyc >= 700) && (cyc < 1400);

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cyc, what, got, want);
    err_count++;
  endtask

  // works out the code points one accepted byte produces
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic eot);
    logic [CpW-1:0] pts [2];
    int  n;
    int  k;
    res_t r;
    n = 0;
    if (seq_left != 0 && b[7:6] == ContMark) begin
      seq_point = {seq_point[CpW-7:0], b[5:0]};
      seq_left  = seq_left - 2'd1;
      if (seq_left == 0) begin
        pts[n] = seq_point;
        n++;
        seq_point = '0;
      end
    end else begin
      // interrupted sequence gives up its partial first
      if (seq_left != 0) begin
        pts[n] = seq_point;
        n++;
        seq_point = '0;
        seq_left  = '0;
      end
      if (!b[7]) begin
        pts[n] = CpW'(b);
        n++;
      end else if (b[7:5] == LeadTwo) begin
        seq_point = CpW'(b[4:0]);
        seq_left  = 2'd1;
      end else if (b[7:4] == LeadThree) begin
        seq_point = CpW'(b[3:0]);
        seq_left  = 2'd2;
      end else if (b[7:3] == LeadFour) begin
        seq_point = CpW'(b[2:0]);
        seq_left  = 2'd3;
      end else begin
        pts[n] = CpQmark;
        n++;
      end
    end
    if (eot) begin
      if (seq_left != 0 && n < 2) begin
        pts[n] = seq_point;
        n++;
      end
      seq_point = '0;
      seq_left  = '0;
    end
    for (k = 0; k < n; k++) begin
      r.code_point = pts[k];
      r.run_last   = (k == n - 1);
      r.text_done  = (k == n - 1) && eot;
      decoded_q.insert(decoded_q.size(), r);
    end
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b, input logic eot);
    text_byte_t t;
    t.text = b;
    t.eot  = eot;
    byte_q.insert(byte_q.size(), t);
  endtask

  // lead plus up to len-1 continuations; keep < len truncates the sequence
  task automatic push_seq(input int len, input int keep, input logic eot);
    logic [ByteW-1:0] lead;
    int k;
    case (len)
      1: lead = {1'b0, 7'($urandom)};
      2: lead = {LeadTwo, 5'($urandom)};
      3: lead = {LeadThree, 4'($urandom)};
      default: lead = {LeadFour, 3'($urandom)};
    endcase
    for (k = 0; k < keep; k++)
      push_byte((k == 0) ? lead : {ContMark, 6'($urandom)}, eot && (k == keep - 1));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        decode_byte(in_text_byte, in_end_of_text);
      if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
        next_byte = byte_q.pop_front();
        in_text_byte   <= next_byte.text;
        in_end_of_text <= next_byte.eot;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected transaction, code_point", int'(out_code_point), 0);
        end else begin
          if (out_code_point !== decoded_q[0].code_point)
            report_mismatch("code_point", int'(out_code_point),
                            int'(decoded_q[0].code_point));
          if (out_run_last !== decoded_q[0].run_last)
            report_mismatch("run_last", int'(out_run_last), int'(decoded_q[0].run_last));
          if (out_text_done !== decoded_q[0].text_done)
            report_mismatch("text_done", int'(out_text_done), int'(decoded_q[0].text_done));
          void'(decoded_q.pop_front());
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    int len;
    // ascii extremes
    push_byte(8'h00, 1'b0);
    push_byte(8'h7f, 1'b0);
    // two, three and four byte sequences, the last one at the 21-bit ceiling
    push_byte(8'hc2, 1'b0);
    push_byte(8'ha9, 1'b0);
    push_byte(8'he2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hac, 1'b0);
    push_byte(8'hf7, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(8'hbf, 1'b0);
    // invalid leads: stray continuation and the f8..ff range
    push_byte(8'h80, 1'b0);
    push_byte(8'hf8, 1'b0);
    push_byte(8'hff, 1'b0);
    // interrupted by ascii, then by an invalid lead
    push_byte(8'he2, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hf0, 1'b0);
    push_byte(8'hf8, 1'b0);
    // interrupted by a lead that ends the text still open
    push_byte(8'hc3, 1'b0);
    push_byte(8'he2, 1'b1);
    // end of text mid-sequence, then on plain ascii
    push_byte(8'he2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'h41, 1'b1);

    while (byte_q.size() < RandomBytes + 23) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (pick < 75) begin
        push_seq(len, len, $urandom_range(0, 9) == 0);
      end else if (pick < 87) begin
        if (len == 1)
          len = 2;
        push_seq(len, $urandom_range(1, len - 1), $urandom_range(0, 2) == 0);
      end else begin
        push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid)
      @(posedge clk);
    while (decoded_q.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (decoded_q.size() != 0)
      report_mismatch("results never delivered, count", 0, decoded_q.size());
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: utf8_stream_decoder_core.f
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8d_outq.sv
rtl/utf8_stream_decoder_core.sv
rtl/utf8d_chk.sv
tb/utf8_stream_decoder_core_test.sv
